// ===== design/capped_exponential_backoff_jitter_defines.svh =====
// Assertion macros shared by the backoff block.
`ifndef CAPPED_EXPONENTIAL_BACKOFF_JITTER_DEFINES_SVH
`define CAPPED_EXPONENTIAL_BACKOFF_JITTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CEBJ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CEBJ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cebj_pkg.sv =====
package cebj_pkg;

  localparam int RETRY_BITS = 8;
  localparam int FRAC_BITS  = 16;

  localparam int DELAY_W  = 32;
  localparam int GROW_W   = 16;
  localparam int GROW_FB  = 8;
  localparam int SPREAD_W = 17;
  localparam int RAND_W   = 16;

  // Jitter factor is UQ2.32; it never reaches 2^34.
  localparam int JF_W = 34;

  // Width of the fixed-point running delay.
  localparam int V_W = DELAY_W + FRAC_BITS;

  // The shared multiplier works on one 16-bit digit of each operand, or on the 17-bit spread.
  localparam int DIG_W    = 16;
  localparam int MUL_W    = 17;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int V_DIGITS = (V_W + DIG_W - 1) / DIG_W;
  localparam int STEP_W   = 3;

  localparam int ACC_W = (V_W + GROW_W > DELAY_W + JF_W) ? V_W + GROW_W : DELAY_W + JF_W;

  localparam logic [GROW_W-1:0]   GROW_ONE   = GROW_W'(256);
  localparam logic [SPREAD_W-1:0] SPREAD_ONE = SPREAD_W'(65536);

  localparam int ADDR_W = 4;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_INITIAL = 2'd0;
  localparam logic [1:0] REG_MAX     = 2'd1;
  localparam logic [1:0] REG_GROWTH  = 2'd2;
  localparam logic [1:0] REG_SPREAD  = 2'd3;

endpackage

// ===== design/capped_exponential_backoff_jitter.sv =====
// Channel   Signals                              Transaction
// input     in_valid, in_stall                   retry_index, random_fraction
// output    out_valid, out_stall                 delay_ms
// config    psel, penable, pwrite, paddr, ...    32-bit registers at 4*i
//
// A transaction first grows the delay in k multiplier iterations, where k is
// at most retry_index (fewer once the cap is reached, none at unity growth),
// then applies jitter when both delay and spread are nonzero, then hands the
// result over. All products go through one 17x17 multiplier, one digit a cycle.
// Reset is synchronous and restores the register defaults; no clearing pass.
// A finished result waits in the output register, so the next transaction is
// accepted while a stalled result is still pending.
`include "capped_exponential_backoff_jitter_defines.svh"

module capped_exponential_backoff_jitter
  import cebj_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [RETRY_BITS-1:0] retry_index,
  input  logic [RAND_W-1:0]     random_fraction,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DELAY_W-1:0]    delay_ms,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_GROW = 2'd1;
  localparam logic [1:0] ST_JIT  = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  localparam logic [STEP_W-1:0] GROW_LAST = STEP_W'(V_DIGITS - 1);
  localparam logic [STEP_W-1:0] JIT_LAST  = STEP_W'(6);

  logic [DELAY_W-1:0]  initial_delay_ms;
  logic [DELAY_W-1:0]  max_delay_ms;
  logic [GROW_W-1:0]   growth_factor;
  logic [SPREAD_W-1:0] jitter_spread;

  logic [1:0]            state;
  logic [STEP_W-1:0]     step;
  logic [RETRY_BITS-1:0] n_q;
  logic [RETRY_BITS-1:0] retry_cnt;
  logic [RAND_W-1:0]     frac_q;
  logic [V_W-1:0]        v;
  logic [DELAY_W-1:0]    d_q;
  logic [JF_W-1:0]       f_q;
  logic [ACC_W-1:0]      acc;
  logic [DELAY_W-1:0]    result;

  logic [DELAY_W-1:0]  cap;
  logic [V_W-1:0]      capfix;
  logic [GROW_W-1:0]   g_eff;
  logic [SPREAD_W-1:0] s_eff;
  logic                cfg_wr;
  logic                in_acc;
  logic                grow_done;
  logic [DELAY_W-1:0]  d_grow;

  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] pp;
  logic [STEP_W-1:0] shift_digits;
  logic [STEP_W-1:0] jk;
  logic [ACC_W-1:0]  acc_sum;
  logic [ACC_W-1:0]  grow_new;
  logic [ACC_W-1:0]  jit_res;
  logic [JF_W-1:0]   f_calc;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    case (paddr[3:2])
      REG_INITIAL: prdata = initial_delay_ms;
      REG_MAX:     prdata = max_delay_ms;
      REG_GROWTH:  prdata = 32'(growth_factor);
      REG_SPREAD:  prdata = 32'(jitter_spread);
      default:     prdata = '0;
    endcase
  end

  assign cap    = (max_delay_ms > initial_delay_ms) ? max_delay_ms : initial_delay_ms;
  assign capfix = {cap, FRAC_BITS'(0)};
  assign g_eff  = (growth_factor < GROW_ONE) ? GROW_ONE : growth_factor;
  assign s_eff  = (jitter_spread > SPREAD_ONE) ? SPREAD_ONE : jitter_spread;

  // Growth stops at the exponent, at unity growth, or once the cap is reached.
  assign grow_done = (retry_cnt == n_q) || (g_eff == GROW_ONE) || (v >= capfix);
  assign d_grow    = DELAY_W'(v >> FRAC_BITS);

  // Operand selection for the shared multiplier.
  assign jk = step - STEP_W'(1);
  always_comb begin
    mul_a        = '0;
    mul_b        = '0;
    shift_digits = '0;
    case (state)
      ST_GROW: begin
        mul_a        = MUL_W'(DIG_W'(v >> (DIG_W * step)));
        mul_b        = MUL_W'(g_eff);
        shift_digits = step;
      end
      ST_JIT: begin
        if (step == '0) begin
          mul_a = MUL_W'(s_eff);
          mul_b = MUL_W'(frac_q);
        end else begin
          mul_a        = MUL_W'(DIG_W'(d_q >> (DIG_W * jk[0])));
          mul_b        = MUL_W'(DIG_W'(f_q >> (DIG_W * jk[2:1])));
          shift_digits = STEP_W'(jk[0]) + STEP_W'(jk[2:1]);
        end
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign pp      = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign acc_sum = acc + (ACC_W'(pp) << (DIG_W * shift_digits));

  always_comb begin
    grow_new = acc_sum >> GROW_FB;
    if (grow_new > ACC_W'(capfix)) begin
      grow_new = ACC_W'(capfix);
    end
  end

  always_comb begin
    jit_res = acc_sum >> (2 * DIG_W);
    if (jit_res > ACC_W'(cap)) begin
      jit_res = ACC_W'(cap);
    end
  end

  // F = 1 - s + 2*s*f, in UQ2.32.
  assign f_calc = (JF_W'(1) << (2 * DIG_W)) - (JF_W'(s_eff) << DIG_W) + (JF_W'(pp) << 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_delay_ms <= DELAY_W'(100);
      max_delay_ms     <= DELAY_W'(1000);
      growth_factor    <= GROW_W'(512);
      jitter_spread    <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_INITIAL: initial_delay_ms <= pwdata;
        REG_MAX:     max_delay_ms     <= pwdata;
        REG_GROWTH:  growth_factor    <= pwdata[GROW_W-1:0];
        REG_SPREAD:  jitter_spread    <= pwdata[SPREAD_W-1:0];
        default:     initial_delay_ms <= initial_delay_ms;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      retry_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      // In the hold state the handover below decides out_valid on its own.
      if (out_valid && !out_stall && state != ST_HOLD) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            n_q       <= retry_index;
            frac_q    <= random_fraction;
            v         <= {initial_delay_ms, FRAC_BITS'(0)};
            retry_cnt <= '0;
            step      <= '0;
            acc       <= '0;
            state     <= ST_GROW;
          end
        end
        ST_GROW: begin
          if (step == '0 && grow_done) begin
            if (d_grow != '0 && s_eff != '0) begin
              d_q   <= d_grow;
              state <= ST_JIT;
            end else begin
              result <= d_grow;
              state  <= ST_HOLD;
            end
          end else if (step == GROW_LAST) begin
            v         <= V_W'(grow_new);
            acc       <= '0;
            step      <= '0;
            retry_cnt <= retry_cnt + RETRY_BITS'(1);
          end else begin
            acc  <= acc_sum;
            step <= step + STEP_W'(1);
          end
        end
        ST_JIT: begin
          if (step == '0) begin
            f_q  <= f_calc;
            acc  <= '0;
            step <= step + STEP_W'(1);
          end else if (step == JIT_LAST) begin
            result <= DELAY_W'(jit_res);
            step   <= '0;
            state  <= ST_HOLD;
          end else begin
            acc  <= acc_sum;
            step <= step + STEP_W'(1);
          end
        end
        ST_HOLD: begin
          if (!out_valid || !out_stall) begin
            delay_ms  <= result;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `CEBJ_ASSERT_NEXT(a_accept_starts, in_acc, (state == ST_GROW) && (retry_cnt == '0) && (step == '0), "transaction accepted without a fresh growth sequence")
  `CEBJ_ASSERT_SAME(a_retry_bound, state == ST_GROW, retry_cnt <= n_q, "growth ran past the retry number")
  `CEBJ_ASSERT_SAME(a_jit_nonzero, state == ST_JIT, d_q != '0, "jitter entered with a zero delay")
  `CEBJ_ASSERT_NEXT(a_hold_handover, (state == ST_HOLD) && (!out_valid || !out_stall), out_valid && (state == ST_IDLE), "finished result not handed to the output register")

endmodule

// ===== tb/capped_exponential_backoff_jitter_test.sv =====
module capped_exponential_backoff_jitter_test
  import cebj_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 850;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 800;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [RETRY_BITS-1:0] retry_index = '0;
  logic [RAND_W-1:0]     random_fraction = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DELAY_W-1:0]    delay_ms;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  logic no_gaps = 1'b0;
  int   quiet_cycles = 0;

  class backoff_scoreboard;
    logic [DELAY_W-1:0]  first_ms;
    logic [DELAY_W-1:0]  limit_ms;
    logic [GROW_W-1:0]   growth;
    logic [SPREAD_W-1:0] spread;
    logic [DELAY_W-1:0]  expected_delays[$];
    bit                  failed;

    function new();
      first_ms = 100;
      limit_ms = 1000;
      growth   = 512;
      spread   = 0;
      failed   = 1'b0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_INITIAL: first_ms = value;
        REG_MAX:     limit_ms = value;
        REG_GROWTH:  growth = value[GROW_W-1:0];
        REG_SPREAD:  spread = value[SPREAD_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [DELAY_W-1:0] backoff_delay(logic [RETRY_BITS-1:0] retry,
                                               logic [RAND_W-1:0] frac);
      logic [DELAY_W-1:0]           cap;
      logic [DELAY_W+FRAC_BITS-1:0] cap_fix;
      logic [79:0]                  running;
      logic [79:0]                  whole;
      logic [63:0]                  factor;
      logic [GROW_W-1:0]            g;
      logic [SPREAD_W-1:0]          s;
      int                           k;
      cap     = (limit_ms > first_ms) ? limit_ms : first_ms;
      cap_fix = {cap, {FRAC_BITS{1'b0}}};
      g       = (growth < GROW_ONE) ? GROW_ONE : growth;
      s       = (spread > SPREAD_ONE) ? SPREAD_ONE : spread;
      running = {first_ms, {FRAC_BITS{1'b0}}};
      if (running > cap_fix)
        running = cap_fix;
      // A growth of exactly one leaves the delay where it started.
      if (g != GROW_ONE) begin
        for (k = 0; k < retry && running < cap_fix; k++) begin
          running = (running * g) >> GROW_FB;
          if (running > cap_fix)
            running = cap_fix;
        end
      end
      whole = running >> FRAC_BITS;
      if (whole != 0 && s != 0) begin
        factor = (64'd1 << 32) - (64'(s) << 16) + 64'd2 * s * frac;
        whole = (whole * factor) >> 32;
        if (whole > cap)
          whole = cap;
      end
      return whole[DELAY_W-1:0];
    endfunction

    function void note_request(logic [RETRY_BITS-1:0] retry, logic [RAND_W-1:0] frac);
      expected_delays.push_back(backoff_delay(retry, frac));
    endfunction

    function void check_delay(logic [DELAY_W-1:0] actual);
      logic [DELAY_W-1:0] wanted;
      if (expected_delays.size() == 0) begin
        $display("%0t: delay_ms %0d arrived with no transaction outstanding", $time, actual);
        failed = 1'b1;
      end else begin
        wanted = expected_delays.pop_front();
        if (actual !== wanted) begin
          $display("%0t: delay_ms expected %0d, got %0d", $time, wanted, actual);
          failed = 1'b1;
        end
      end
    endfunction

    function int pending();
      return expected_delays.size();
    endfunction
  endclass

  backoff_scoreboard board;

  capped_exponential_backoff_jitter dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .retry_index     (retry_index),
    .random_fraction (random_fraction),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .delay_ms        (delay_ms),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Values read here are those from just before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        board.note_request(retry_index, random_fraction);
      if (out_valid && !out_stall)
        board.check_delay(delay_ms);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    out_stall <= !rst && !no_gaps && ($urandom_range(0, 99) < 18);
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  task automatic push_request(logic [RETRY_BITS-1:0] retry, logic [RAND_W-1:0] frac);
    while (!no_gaps && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    retry_index     <= retry;
    random_fraction <= frac;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    board.set_register(idx, value);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do
      @(negedge clk);
    while (board.pending() != 0);
    @(posedge clk);
  endtask

  // Registers change only once every outstanding transaction has come back.
  task automatic apply_settings(logic [31:0] first_word, logic [31:0] max_word,
                                logic [31:0] growth_word, logic [31:0] spread_word);
    wait_drained();
    write_reg(REG_INITIAL, first_word);
    write_reg(REG_MAX, max_word);
    write_reg(REG_GROWTH, growth_word);
    write_reg(REG_SPREAD, spread_word);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_settings();
    logic [31:0]         first_word;
    logic [31:0]         max_word;
    logic [GROW_W-1:0]   growth;
    logic [SPREAD_W-1:0] spread;
    case ($urandom_range(0, 5))
      0:       first_word = 32'd0;
      1:       first_word = 32'hFFFF_FFFF;
      2:       first_word = $urandom_range(1, 20);
      3:       first_word = $urandom_range(1, 5000);
      default: first_word = $urandom;
    endcase
    case ($urandom_range(0, 4))
      0:       max_word = 32'd0;
      1:       max_word = 32'hFFFF_FFFF;
      2:       max_word = $urandom_range(1, 100000);
      3:       max_word = $urandom;
      default: max_word = first_word + $urandom_range(0, 100000);
    endcase
    case ($urandom_range(0, 5))
      0:       growth = $urandom_range(0, 255);
      1:       growth = GROW_ONE;
      2:       growth = $urandom_range(257, 1023);
      3:       growth = 16'hFFFF;
      default: growth = $urandom_range(256, 16'hFFFF);
    endcase
    case ($urandom_range(0, 5))
      0:       spread = '0;
      1:       spread = SPREAD_ONE;
      2:       spread = $urandom_range(65537, 131071);
      3:       spread = $urandom_range(1, 255);
      default: spread = $urandom_range(0, 65536);
    endcase
    // Bits above each register's width are noise and must be dropped.
    apply_settings(first_word, max_word, {16'($urandom), growth}, {15'($urandom), spread});
  endtask

  initial begin
    int                  sent;
    int                  burst;
    logic [RETRY_BITS-1:0] retry;
    logic [RAND_W-1:0]     frac;
    board = new();
    sent  = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Defaults after reset: no jitter, so the fraction has no effect.
    push_request(8'd0, 16'h0000);
    push_request(8'd1, 16'hFFFF);
    push_request(8'd3, 16'h1234);
    push_request(8'd4, 16'h0000);
    push_request(8'd255, 16'hFFFF);

    // A zero starting delay stays zero whatever the growth and jitter.
    apply_settings(32'd0, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0001_0000);
    push_request(8'd0, 16'h0000);
    push_request(8'd255, 16'hFFFF);

    // Maximum below the start, growth below one and spread beyond one.
    apply_settings(32'hFFFF_FFFF, 32'd0, 32'h0000_00FF, 32'h0001_FFFF);
    push_request(8'd255, 16'h0000);
    push_request(8'd7, 16'hFFFF);
    push_request(8'd0, 16'h8000);

    apply_settings(32'd1, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0001_0000);
    push_request(8'd255, 16'hFFFF);
    push_request(8'd255, 16'h0000);
    push_request(8'd1, 16'h8000);
    push_request(8'd2, 16'h0001);

    apply_settings(32'd3, 32'd50, 32'd384, 32'd1);
    push_request(8'd10, 16'hFFFF);
    push_request(8'd10, 16'h0000);
    push_request(8'd255, 16'h5555);

    // Growth just above one needs the full count of iterations.
    apply_settings(32'd1000, 32'hFFFF_FFFF, 32'd257, 32'd32768);
    push_request(8'd255, 16'hAAAA);
    push_request(8'd128, 16'h7FFF);

    while (sent < RANDOM_ITEMS) begin
      random_settings();
      burst = $urandom_range(20, 60);
      repeat (burst) begin
        no_gaps <= (sent >= 350 && sent < 500);
        case ($urandom_range(0, 4))
          0:       retry = $urandom_range(0, 7);
          1:       retry = $urandom_range(0, 31);
          2:       retry = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
          default: retry = $urandom_range(0, 255);
        endcase
        case ($urandom_range(0, 7))
          0:       frac = 16'h0000;
          1:       frac = 16'hFFFF;
          default: frac = 16'($urandom);
        endcase
        push_request(retry, frac);
        sent++;
      end
    end

    no_gaps <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!board.failed && board.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
